// ----- rtl/hse_pkg.sv -----
// ----------------------------------------------------------------------------
// Heap sort engine package
// Field widths and payload types shared by the stream interfaces and the core.
// ----------------------------------------------------------------------------
`default_nettype none

package hse_pkg;

	// Width of the key fields carried on both streams.
	localparam int FIELD_W = 32;

	typedef logic [FIELD_W-1:0] key_field_t;

endpackage : hse_pkg

`default_nettype wire

// ----- rtl/hse_stream_if.sv -----
// ----------------------------------------------------------------------------
// Heap sort engine stream interfaces
// Valid/ready channels for incoming keys and for sorted results.
// ----------------------------------------------------------------------------
`default_nettype none

// Incoming keys, one per transaction, with a flag on the last key of a run.
interface hse_key_if;
	logic                valid;
	logic                ready;
	hse_pkg::key_field_t key;
	logic                final_key;

	modport source (output valid, output key, output final_key, input ready);
	modport sink   (input valid, input key, input final_key, output ready);
endinterface : hse_key_if

// Sorted keys, ascending, with a flag on the last key of a run.
interface hse_sorted_if;
	logic                valid;
	logic                ready;
	hse_pkg::key_field_t sorted_key;
	logic                final_out;

	modport source (output valid, output sorted_key, output final_out, input ready);
	modport sink   (input valid, input sorted_key, input final_out, output ready);
endinterface : hse_sorted_if

`default_nettype wire

// ----- rtl/heap_sort_engine_core.sv -----
// Loading: a key is inserted into the heap as it arrives, climbing one level per parent read
// and compare; no new key is taken until the insert ends, as ready is high only in idle.
// Sorting: each extraction reads the root and the last key and swaps the root to the end, then
// reads both children and compares at each level, with a final check when the key ends in a leaf.
// Output: one sorted key per cycle while the sink is ready, each read from memory and then registered.
// Reset clears the control state and key count; the key memory is not cleared.
// ----------------------------------------------------------------------------
// Heap sort engine core
// Collects a run of keys into a max-heap held in one memory, heap-sorts it in
// place on the last key, and streams the keys out in ascending order.
// ----------------------------------------------------------------------------
`default_nettype none

module heap_sort_engine_core #(
	parameter int MAX_ITEMS = 64,
	parameter int KEY_BITS  = 32
) (
	input  wire                 clk,
	input  wire                 arst_n,
	hse_key_if.sink             keys,
	hse_sorted_if.source        sorted
);

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);

	typedef logic [AW-1:0]       addr_t;
	typedef logic [CW-1:0]       count_t;
	typedef logic [KEY_BITS-1:0] key_t;

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b00_0000_0001,
		ST_UP_RD    = 10'b00_0000_0010,
		ST_UP_CMP   = 10'b00_0000_0100,
		ST_DN_ROOT  = 10'b00_0000_1000,
		ST_DN_LAST  = 10'b00_0001_0000,
		ST_DN_PLACE = 10'b00_0010_0000,
		ST_DN_RDL   = 10'b00_0100_0000,
		ST_DN_RDR   = 10'b00_1000_0000,
		ST_DN_CMP   = 10'b01_0000_0000,
		ST_OUT      = 10'b10_0000_0000
	} state_t;

	// Control registers.
	state_t state_q, state_d;
	count_t count_q, count_d;
	count_t out_idx_q, out_idx_d;
	addr_t  pos_q, pos_d;
	addr_t  end_q, end_d;
	logic   fin_q, fin_d;
	logic   has_r_q, has_r_d;
	logic   pend_q, pend_d;
	logic   out_valid_q, out_valid_d;

	// Payload registers.
	key_t                cur_q, cur_d;
	key_t                top_q, top_d;
	key_t                lval_q, lval_d;
	logic                pend_last_q, pend_last_d;
	hse_pkg::key_field_t out_key_q, out_key_d;
	logic                out_last_q, out_last_d;

	// Key memory with a registered read port.
	key_t  key_mem [MAX_ITEMS];
	key_t  rd_data_q;
	logic  wr_en, rd_en;
	addr_t wr_addr, rd_addr;
	key_t  wr_data;

	// Heap index arithmetic around the current position.
	logic [AW:0]   left_w;
	logic [AW+1:0] right_w;
	addr_t         parent;
	logic          left_ok, right_ok;
	logic          pick_right;
	key_t          big_val;
	addr_t         big_pos;

	// Sequencing helpers.
	logic go_sort, go_out, out_move, out_issue;

	assign left_w   = {pos_q, 1'b1};
	assign right_w  = {1'b0, left_w} + (AW+2)'(1);
	assign parent   = addr_t'((pos_q - addr_t'(1)) >> 1);
	assign left_ok  = left_w < {1'b0, end_q};
	assign right_ok = right_w < {2'b00, end_q};

	// The left child wins a tie, as the larger child is chosen.
	assign pick_right = has_r_q && (rd_data_q > lval_q);
	assign big_val    = pick_right ? rd_data_q : lval_q;
	assign big_pos    = pick_right ? right_w[AW-1:0] : left_w[AW-1:0];

	assign out_move = pend_q && (!out_valid_q || sorted.ready);

	assign keys.ready        = (state_q == ST_IDLE);
	assign sorted.valid      = out_valid_q;
	assign sorted.sorted_key = out_key_q;
	assign sorted.final_out  = out_last_q;

	// Next-state and memory access logic.
	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		out_idx_d   = out_idx_q;
		pos_d       = pos_q;
		end_d       = end_q;
		fin_d       = fin_q;
		has_r_d     = has_r_q;
		pend_d      = pend_q;
		out_valid_d = out_valid_q;
		cur_d       = cur_q;
		top_d       = top_q;
		lval_d      = lval_q;
		pend_last_d = pend_last_q;
		out_key_d   = out_key_q;
		out_last_d  = out_last_q;
		wr_en       = 1'b0;
		wr_addr     = pos_q;
		wr_data     = cur_q;
		rd_en       = 1'b0;
		rd_addr     = '0;
		go_sort     = 1'b0;
		go_out      = 1'b0;
		out_issue   = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (keys.valid) begin
					if (count_q < count_t'(MAX_ITEMS)) begin
						cur_d   = key_t'(keys.key);
						pos_d   = addr_t'(count_q);
						count_d = count_q + count_t'(1);
						fin_d   = keys.final_key;
						state_d = ST_UP_RD;
					end else if (keys.final_key) begin
						// Buffer full: the key is dropped but the run still ends.
						go_sort = 1'b1;
					end
				end
			end
			ST_UP_RD: begin
				if (pos_q == '0) begin
					wr_en = 1'b1;
					if (fin_q) begin
						go_sort = 1'b1;
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					rd_en   = 1'b1;
					rd_addr = parent;
					state_d = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				wr_en = 1'b1;
				if (cur_q > rd_data_q) begin
					// Pull the parent down into the hole and climb.
					wr_data = rd_data_q;
					pos_d   = parent;
					state_d = ST_UP_RD;
				end else if (fin_q) begin
					go_sort = 1'b1;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DN_ROOT: begin
				rd_en   = 1'b1;
				rd_addr = '0;
				state_d = ST_DN_LAST;
			end
			ST_DN_LAST: begin
				top_d   = rd_data_q;
				rd_en   = 1'b1;
				rd_addr = end_q;
				state_d = ST_DN_PLACE;
			end
			ST_DN_PLACE: begin
				// The root goes to the end; the last key sifts down from the root.
				cur_d   = rd_data_q;
				wr_en   = 1'b1;
				wr_addr = end_q;
				wr_data = top_q;
				pos_d   = '0;
				state_d = ST_DN_RDL;
			end
			ST_DN_RDL: begin
				if (left_ok) begin
					rd_en   = 1'b1;
					rd_addr = left_w[AW-1:0];
					state_d = ST_DN_RDR;
				end else begin
					wr_en = 1'b1;
					if (end_q == addr_t'(1)) begin
						go_out = 1'b1;
					end else begin
						end_d   = end_q - addr_t'(1);
						state_d = ST_DN_ROOT;
					end
				end
			end
			ST_DN_RDR: begin
				lval_d  = rd_data_q;
				has_r_d = right_ok;
				if (right_ok) begin
					rd_en   = 1'b1;
					rd_addr = right_w[AW-1:0];
				end
				state_d = ST_DN_CMP;
			end
			ST_DN_CMP: begin
				wr_en = 1'b1;
				if (cur_q < big_val) begin
					// Lift the larger child into the hole and descend.
					wr_data = big_val;
					pos_d   = big_pos;
					state_d = ST_DN_RDL;
				end else if (end_q == addr_t'(1)) begin
					go_out = 1'b1;
				end else begin
					end_d   = end_q - addr_t'(1);
					state_d = ST_DN_ROOT;
				end
			end
			ST_OUT: begin
				out_issue = (!pend_q || out_move) && (out_idx_q < count_q);
				if (out_issue) begin
					rd_en       = 1'b1;
					rd_addr     = out_idx_q[AW-1:0];
					pend_last_d = (out_idx_q + count_t'(1)) == count_q;
					out_idx_d   = out_idx_q + count_t'(1);
					pend_d      = 1'b1;
				end else if (out_move) begin
					pend_d = 1'b0;
				end
				if ((out_idx_q == count_q) && (!pend_q || out_move)) begin
					count_d = '0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// Start of the sort, or straight to output for a single key or none.
		if (go_sort) begin
			if (count_q <= count_t'(1)) begin
				go_out = 1'b1;
			end else begin
				end_d   = addr_t'(count_q - count_t'(1));
				state_d = ST_DN_ROOT;
			end
		end
		if (go_out) begin
			out_idx_d = '0;
			pend_d    = 1'b0;
			state_d   = ST_OUT;
		end

		// Output register, loaded from the fetched key when free or being taken.
		if (out_move) begin
			out_valid_d = 1'b1;
			out_key_d   = hse_pkg::key_field_t'(rd_data_q);
			out_last_d  = pend_last_q;
		end else if (out_valid_q && sorted.ready) begin
			out_valid_d = 1'b0;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_idx_q   <= '0;
			pos_q       <= '0;
			end_q       <= '0;
			fin_q       <= 1'b0;
			has_r_q     <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_idx_q   <= out_idx_d;
			pos_q       <= pos_d;
			end_q       <= end_d;
			fin_q       <= fin_d;
			has_r_q     <= has_r_d;
			pend_q      <= pend_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		cur_q       <= cur_d;
		top_q       <= top_d;
		lval_q      <= lval_d;
		pend_last_q <= pend_last_d;
		out_key_q   <= out_key_d;
		out_last_q  <= out_last_d;
	end

	// Key memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= key_mem[rd_addr];
		end
	end

endmodule : heap_sort_engine_core

`default_nettype wire

// ----- rtl/hse_checker.sv -----
// ----------------------------------------------------------------------------
// Heap sort engine port checker
// Watches the core's streams and checks results against the runs that have ended.
// ----------------------------------------------------------------------------
`default_nettype none

module hse_checker #(
	parameter int MAX_ITEMS = 64
) (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_valid,
	input wire                 in_ready,
	input wire                 in_final,
	input wire                 out_valid,
	input wire                 out_ready,
	input wire [31:0]          out_key,
	input wire                 out_final
);

	localparam int CW = $clog2(MAX_ITEMS + 1);

	logic [1:0]    runs_due_q;
	logic [CW-1:0] out_cnt_q;
	logic          in_xfer, out_xfer;
	logic          run_in, run_out;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;
	assign run_in   = in_xfer && in_final;
	assign run_out  = out_xfer && out_final;

	// Count the runs that have ended and whose results are still due.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runs_due_q <= '0;
			out_cnt_q  <= '0;
		end else begin
			if (run_in && !run_out) begin
				runs_due_q <= runs_due_q + 2'd1;
			end else if (run_out && !run_in) begin
				runs_due_q <= runs_due_q - 2'd1;
			end
			if (run_out) begin
				out_cnt_q <= '0;
			end else if (out_xfer) begin
				out_cnt_q <= out_cnt_q + CW'(1);
			end
		end
	end

	// No result is shown during reset.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_final))
		else $error("stalled result changed");

	// Results appear only for a run that has ended.
	a_out_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (runs_due_q != 2'd0))
		else $error("result without a finished run");

	// A run never yields more results than the buffer holds.
	a_out_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> (out_cnt_q < CW'(MAX_ITEMS)))
		else $error("too many results in one run");

endmodule : hse_checker

bind heap_sort_engine_core hse_checker #(
	.MAX_ITEMS (MAX_ITEMS)
) u_hse_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (keys.valid),
	.in_ready  (keys.ready),
	.in_final  (keys.final_key),
	.out_valid (sorted.valid),
	.out_ready (sorted.ready),
	.out_key   (sorted.sorted_key),
	.out_final (sorted.final_out)
);

`default_nettype wire
